// ===== hdl/text_view_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Text view filter assertion macros
// Concurrent check wrappers, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef TEXT_VIEW_FILTER_MACROS_SVH
`define TEXT_VIEW_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define TVF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TVF_ASSERT_IMP(label, ante, cons, msg)
`define TVF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/tvf_pkg.sv =====
// ----------------------------------------------------------------------------
// Text view filter package
// Widths, character codes and register indexes shared by the filter files.
// ----------------------------------------------------------------------------
package tvf_pkg;

  localparam int BYTE_W     = 8;
  localparam int MIN_WIDTH  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_ENDS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_CTRL       = 3'd5;

  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL       = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DOLLAR   = 8'h24;
  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_QUEST    = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_I        = 8'h49;
  localparam logic [BYTE_W-1:0] CH_CARET    = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_DEL      = 8'd127;
  localparam logic [BYTE_W-1:0] CTRL_MAX    = 8'd31;
  localparam logic [BYTE_W-1:0] CTRL_OFFSET = 8'd64;

  localparam logic [3:0] BCD_NINE = 4'd9;

endpackage

// ===== hdl/tvf_ifs.sv =====
// ----------------------------------------------------------------------------
// Text view filter channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface tvf_in_if import tvf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_of_file;

  modport source (output valid, data_byte, first_of_file, input ready);
  modport sink   (input valid, data_byte, first_of_file, output ready);
endinterface

interface tvf_out_if import tvf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

interface tvf_cfg_if import tvf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/text_view_filter.sv =====
// ----------------------------------------------------------------------------
// Text view filter
// Byte stream to display stream: line numbers, blank squeeze, end marks, caret notation.
// ----------------------------------------------------------------------------
// Each accepted input word yields its display bytes one per cycle, while the
// output is not stalled, from a job register into an output register. A plain
// byte yields one byte; a shown tab, control byte or marked newline yields two;
// a numbered line start first adds the number, space-padded to at least 6
// columns, and its tab. A squeezed blank line is taken and yields nothing. The
// next word is accepted in the cycle the last byte of the current one moves to
// the output register, so plain text streams at one byte per unstalled cycle.
`include "text_view_filter_macros.svh"

module text_view_filter import tvf_pkg::*; #(
  parameter int NUMBER_DIGITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  tvf_in_if.sink     in_ch,
  tvf_out_if.source  out_ch,
  tvf_cfg_if.sink    cfg_ch
);

  localparam int LN_W  = 4 * NUMBER_DIGITS;
  localparam int IDX_W = $clog2(NUMBER_DIGITS);
  localparam logic [IDX_W-1:0] IDX_MIN = IDX_W'(MIN_WIDTH - 1);

  localparam logic [1:0] PH_NUM = 2'd0;
  localparam logic [1:0] PH_TAB = 2'd1;
  localparam logic [1:0] PH_B0  = 2'd2;
  localparam logic [1:0] PH_B1  = 2'd3;

  logic num_all_r, num_nonblank_r, squeeze_r, mark_ends_r, show_tabs_r, show_ctrl_r;

  logic [LN_W-1:0] line_number_r, line_number_nxt;
  logic            at_line_start_r, prev_blank_r;

  logic              job_valid_r;
  logic [1:0]        job_phase_r;
  logic [IDX_W-1:0]  job_idx_r, job_msd_r;
  logic [LN_W-1:0]   job_ln_r;
  logic [BYTE_W-1:0] job_b0_r, job_b1_r;
  logic              job_two_r;

  logic              out_valid_r, out_last_r;
  logic [BYTE_W-1:0] out_byte_r;

  logic              in_fire, advance, job_done;
  logic [LN_W-1:0]   ln_eff;
  logic              als, plb, blank, drop, numbered;
  logic [IDX_W-1:0]  msd, start_idx;
  logic [BYTE_W-1:0] body0, body1;
  logic              body_two;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic [3:0]        digit;

  assign advance  = job_valid_r && (!out_valid_r || out_ch.ready);
  assign job_done = advance && emit_last;
  assign in_ch.ready = !job_valid_r || job_done;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  assign ln_eff   = in_ch.first_of_file ? LN_W'(1) : line_number_r;
  assign als      = in_ch.first_of_file || at_line_start_r;
  assign plb      = !in_ch.first_of_file && prev_blank_r;
  assign blank    = (in_ch.data_byte == CH_NL);
  assign drop     = als && squeeze_r && plb && blank;
  assign numbered = als && !drop && (num_nonblank_r ? !blank : num_all_r);
  assign start_idx = (msd > IDX_MIN) ? msd : IDX_MIN;

  always_comb begin
    msd = '0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (ln_eff[4*i +: 4] != 4'd0) msd = IDX_W'(i);
    end
  end

  always_comb begin
    logic       all_nines;
    logic       carry;
    logic [3:0] d;
    all_nines = 1'b1;
    carry     = 1'b1;
    d         = '0;
    line_number_nxt = ln_eff;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (ln_eff[4*i +: 4] != BCD_NINE) all_nines = 1'b0;
    end
    if (numbered && !all_nines) begin
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        d = ln_eff[4*i +: 4];
        if (carry) begin
          if (d >= BCD_NINE) begin
            line_number_nxt[4*i +: 4] = 4'd0;
          end else begin
            line_number_nxt[4*i +: 4] = d + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    body0    = in_ch.data_byte;
    body1    = in_ch.data_byte;
    body_two = 1'b0;
    priority if (in_ch.data_byte == CH_NL) begin
      if (mark_ends_r) begin
        body0    = CH_DOLLAR;
        body_two = 1'b1;
      end
    end else if (in_ch.data_byte == CH_TAB) begin
      if (show_tabs_r) begin
        body0    = CH_CARET;
        body1    = CH_I;
        body_two = 1'b1;
      end
    end else if (show_ctrl_r && in_ch.data_byte != 8'd0 && in_ch.data_byte <= CTRL_MAX) begin
      body0    = CH_CARET;
      body1    = in_ch.data_byte + CTRL_OFFSET;
      body_two = 1'b1;
    end else if (show_ctrl_r && in_ch.data_byte == CH_DEL) begin
      body0    = CH_CARET;
      body1    = CH_QUEST;
      body_two = 1'b1;
    end else begin
      body0 = in_ch.data_byte;
    end
  end

  assign digit = job_ln_r[{job_idx_r, 2'b00} +: 4];

  always_comb begin
    emit_byte = job_b0_r;
    emit_last = 1'b0;
    unique case (job_phase_r)
      PH_NUM: begin
        if (job_idx_r > job_msd_r) emit_byte = CH_SPACE;
        else emit_byte = CH_ZERO + BYTE_W'((digit > BCD_NINE) ? BCD_NINE : digit);
      end
      PH_TAB: emit_byte = CH_TAB;
      PH_B0: begin
        emit_byte = job_b0_r;
        emit_last = !job_two_r;
      end
      PH_B1: begin
        emit_byte = job_b1_r;
        emit_last = 1'b1;
      end
      default: emit_byte = job_b0_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_all_r       <= 1'b0;
      num_nonblank_r  <= 1'b0;
      squeeze_r       <= 1'b0;
      mark_ends_r     <= 1'b0;
      show_tabs_r     <= 1'b0;
      show_ctrl_r     <= 1'b0;
      line_number_r   <= LN_W'(1);
      at_line_start_r <= 1'b1;
      prev_blank_r    <= 1'b0;
      job_valid_r     <= 1'b0;
      job_phase_r     <= PH_B0;
      job_idx_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_NUMBER_ALL:      num_all_r      <= cfg_ch.data[0];
          REG_NUMBER_NONBLANK: num_nonblank_r <= cfg_ch.data[0];
          REG_SQUEEZE_BLANK:   squeeze_r      <= cfg_ch.data[0];
          REG_MARK_ENDS:       mark_ends_r    <= cfg_ch.data[0];
          REG_SHOW_TABS:       show_tabs_r    <= cfg_ch.data[0];
          REG_SHOW_CTRL:       show_ctrl_r    <= cfg_ch.data[0];
          default: ;
        endcase
      end

      if (in_fire) begin
        line_number_r   <= line_number_nxt;
        at_line_start_r <= drop ? 1'b1 : blank;
        if (als) prev_blank_r <= blank;
      end

      if (in_fire && !drop) begin
        job_valid_r <= 1'b1;
        job_phase_r <= numbered ? PH_NUM : PH_B0;
        job_idx_r   <= start_idx;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
      end else if (advance) begin
        unique case (job_phase_r)
          PH_NUM: begin
            if (job_idx_r == '0) job_phase_r <= PH_TAB;
            else job_idx_r <= job_idx_r - 1'b1;
          end
          PH_TAB:  job_phase_r <= PH_B0;
          PH_B0:   job_phase_r <= PH_B1;
          PH_B1:   job_phase_r <= PH_B1;
          default: job_phase_r <= PH_B0;
        endcase
      end

      if (advance) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      job_ln_r  <= ln_eff;
      job_msd_r <= msd;
      job_b0_r  <= body0;
      job_b1_r  <= body1;
      job_two_r <= body_two;
    end
    if (advance) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  `TVF_ASSERT_IMP(a_out_from_job, $rose(out_valid_r), $past(job_valid_r), "output word without a job")
  `TVF_ASSERT_IMP(a_ready_on_finish, in_ch.ready && job_valid_r, job_done, "input taken mid job")
  `TVF_ASSERT_IMP(a_second_body, job_valid_r && job_phase_r == PH_B1, job_two_r, "spurious second byte")
  `TVF_ASSERT_NEXT(a_drop_no_job, in_fire && drop && !job_valid_r, !job_valid_r, "dropped line queued")

endmodule
